### src/s2cfm_pkg.sv
// Shared types and constants for the sphere to cube face map.
// Holds face codes, internal fixed-point widths and the sign-code struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package s2cfm_pkg;

   // Default input/output fraction bits
   localparam int DEF_FRAC_BITS = 16;

   // Internal format: unsigned magnitudes with IFB fraction bits
   localparam int IFB    = 28;
   localparam int VEC_W  = 18;
   localparam int MAG_W  = IFB + 1;        // holds 1.0 exactly
   localparam int EXT_W  = VEC_W + 20;     // room for a left shift of up to 20 bits
   localparam int TM_W   = IFB + 3;        // |t| <= 5.0
   localparam int RADA_W = 2 * TM_W;       // t^2 radicand
   localparam int RTA_W  = TM_W;           // root of first radicand
   localparam int DIF_W  = IFB + 2;        // sa - sb, signed
   localparam int NUM_W  = IFB + 6;        // 3 - u - v, signed
   localparam int RADB_W = 2 * (IFB + 1);  // (3 - u - v) / 2 at double precision
   localparam int RTB_W  = IFB + 1;        // root of second radicand
   localparam int STG_A  = RADA_W / 2;     // one result bit per stage
   localparam int STG_B  = RADB_W / 2;

   // Face codes
   localparam logic [2:0] FACE_PX = 3'd0;
   localparam logic [2:0] FACE_NX = 3'd1;
   localparam logic [2:0] FACE_PY = 3'd2;
   localparam logic [2:0] FACE_NY = 3'd3;
   localparam logic [2:0] FACE_PZ = 3'd4;
   localparam logic [2:0] FACE_NZ = 3'd5;

   // Sign of a projected component
   typedef struct packed {
      logic zero;
      logic neg;
   } sgn_type;

endpackage

`default_nettype wire

### src/sphere_to_cube_face_map_top.sv
// Sphere to cube face map: face select, projection and inverse mapping.
// Pipelined from an accepted req beat to the rsp beat; one beat per cycle sustained while the output is not stalled.
// The two pipelined restoring square roots (31 and 29 stages, one root bit each) set the depth.
// The whole pipeline advances unless a finished beat sits stalled in the output register.
// Synchronous active-high reset clears all valid bits; payload registers are not reset.
// Depends on s2cfm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sphere_to_cube_face_map_top #(
   parameter int FRAC_BITS = s2cfm_pkg::DEF_FRAC_BITS
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_stall,
   input  wire signed  [17:0] req_vec_x,
   input  wire signed  [17:0] req_vec_y,
   input  wire signed  [17:0] req_vec_z,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output logic        [2:0]  rsp_face,
   output logic signed [17:0] rsp_face_u,
   output logic signed [17:0] rsp_face_v
);

   localparam int IFB    = s2cfm_pkg::IFB;
   localparam int MAG_W  = s2cfm_pkg::MAG_W;
   localparam int EXT_W  = s2cfm_pkg::EXT_W;
   localparam int TM_W   = s2cfm_pkg::TM_W;
   localparam int RADA_W = s2cfm_pkg::RADA_W;
   localparam int RTA_W  = s2cfm_pkg::RTA_W;
   localparam int DIF_W  = s2cfm_pkg::DIF_W;
   localparam int NUM_W  = s2cfm_pkg::NUM_W;
   localparam int RADB_W = s2cfm_pkg::RADB_W;
   localparam int RTB_W  = s2cfm_pkg::RTB_W;
   localparam int STG_A  = s2cfm_pkg::STG_A;
   localparam int STG_B  = s2cfm_pkg::STG_B;

   // Input alignment to the internal format
   localparam int ShL = (FRAC_BITS <= IFB) ? IFB - FRAC_BITS : 0;
   localparam int ShR = (FRAC_BITS > IFB) ? FRAC_BITS - IFB : 0;
   localparam logic [EXT_W-1:0] OneExt = EXT_W'(1) << IFB;
   localparam logic [MAG_W-1:0] OneMag = MAG_W'(1) << IFB;
   // Output alignment
   localparam int ShO  = (FRAC_BITS < IFB) ? IFB - FRAC_BITS : 0;
   localparam int ShOL = (FRAC_BITS > IFB) ? FRAC_BITS - IFB : 0;
   localparam logic [31:0] RndHalf = (ShO > 0) ? (32'(1) << (ShO - 1)) : 32'd0;
   localparam logic [31:0] Lim     = 32'(1) << FRAC_BITS;

   logic adv;

   // Advance unless the output register holds a stalled beat
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   // ---------------- Stage 1: face select and projection ----------------
   logic        [17:0]      ax, ay, az;
   logic signed [17:0]      a_src, b_src;
   logic        [2:0]       face_in;
   s2cfm_pkg::sgn_type      sa_sgn_in, sb_sgn_in;
   logic        [17:0]      a_abs, b_abs;
   logic        [EXT_W-1:0] a_ext, b_ext;
   logic        [MAG_W-1:0] ma_in, mb_in;

   logic                    s1_vld_ff;
   logic        [2:0]       s1_face_ff;
   s2cfm_pkg::sgn_type      s1_sga_ff, s1_sgb_ff;
   logic        [MAG_W-1:0] s1_ma_ff, s1_mb_ff;

   always_comb begin
      ax = req_vec_x[17] ? 18'(-req_vec_x) : 18'(req_vec_x);
      ay = req_vec_y[17] ? 18'(-req_vec_y) : 18'(req_vec_y);
      az = req_vec_z[17] ? 18'(-req_vec_z) : 18'(req_vec_z);
      if (ax > ay && ax > az) begin
         face_in = (req_vec_x > 0) ? s2cfm_pkg::FACE_PX : s2cfm_pkg::FACE_NX;
         a_src   = req_vec_y;
         b_src   = req_vec_z;
      end else if (ay > ax && ay > az) begin
         face_in = (req_vec_y > 0) ? s2cfm_pkg::FACE_PY : s2cfm_pkg::FACE_NY;
         a_src   = req_vec_z;
         b_src   = req_vec_x;
      end else begin
         face_in = (req_vec_z > 0) ? s2cfm_pkg::FACE_PZ : s2cfm_pkg::FACE_NZ;
         a_src   = req_vec_x;
         b_src   = req_vec_y;
      end
      // Negative faces negate the first component
      sa_sgn_in.zero = (a_src == 18'sd0);
      sa_sgn_in.neg  = face_in[0] ? (!a_src[17] && !sa_sgn_in.zero) : a_src[17];
      sb_sgn_in.zero = (b_src == 18'sd0);
      sb_sgn_in.neg  = b_src[17];
      a_abs = a_src[17] ? 18'(-a_src) : 18'(a_src);
      b_abs = b_src[17] ? 18'(-b_src) : 18'(b_src);
      a_ext = ({{(EXT_W-18){1'b0}}, a_abs} << ShL) >> ShR;
      b_ext = ({{(EXT_W-18){1'b0}}, b_abs} << ShL) >> ShR;
      ma_in = (a_ext > OneExt) ? OneMag : a_ext[MAG_W-1:0];
      mb_in = (b_ext > OneExt) ? OneMag : b_ext[MAG_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= req_valid;
      end
      if (adv) begin
         s1_face_ff <= face_in;
         s1_sga_ff  <= sa_sgn_in;
         s1_sgb_ff  <= sb_sgn_in;
         s1_ma_ff   <= ma_in;
         s1_mb_ff   <= mb_in;
      end
   end

   // ---------------- Stage 2: squares, rounded to Q.28 ----------------
   logic [2*MAG_W-1:0] pa, pb, pa_r, pb_r;
   logic               s2_vld_ff;
   logic [2:0]         s2_face_ff;
   s2cfm_pkg::sgn_type s2_sga_ff, s2_sgb_ff;
   logic [MAG_W-1:0]   s2_sa_ff, s2_sb_ff;

   always_comb begin
      pa   = s1_ma_ff * s1_ma_ff;
      pb   = s1_mb_ff * s1_mb_ff;
      pa_r = (pa + ((2*MAG_W)'(1) << (IFB - 1))) >> IFB;
      pb_r = (pb + ((2*MAG_W)'(1) << (IFB - 1))) >> IFB;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (adv) begin
         s2_vld_ff <= s1_vld_ff;
      end
      if (adv) begin
         s2_face_ff <= s1_face_ff;
         s2_sga_ff  <= s1_sga_ff;
         s2_sgb_ff  <= s1_sgb_ff;
         s2_sa_ff   <= pa_r[MAG_W-1:0];
         s2_sb_ff   <= pb_r[MAG_W-1:0];
      end
   end

   // ---------------- Stage 3: |t| and its square ----------------
   // t = 2 so - 2 s - 3 is always negative; carry |t| = 3 + 2 s - 2 so
   localparam logic [TM_W-1:0] Three = TM_W'(3) << IFB;
   logic [TM_W-1:0]   tm0, tm1;
   logic              s3_vld_ff;
   logic [2:0]        s3_face_ff;
   s2cfm_pkg::sgn_type s3_sga_ff, s3_sgb_ff;
   logic [MAG_W-1:0]  s3_sa_ff, s3_sb_ff;
   logic [RADA_W-1:0] s3_t0sq_ff, s3_t1sq_ff;

   always_comb begin
      tm0 = Three + {1'b0, s2_sa_ff, 1'b0} - {1'b0, s2_sb_ff, 1'b0};
      tm1 = Three + {1'b0, s2_sb_ff, 1'b0} - {1'b0, s2_sa_ff, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (adv) begin
         s3_vld_ff <= s2_vld_ff;
      end
      if (adv) begin
         s3_face_ff <= s2_face_ff;
         s3_sga_ff  <= s2_sga_ff;
         s3_sgb_ff  <= s2_sgb_ff;
         s3_sa_ff   <= s2_sa_ff;
         s3_sb_ff   <= s2_sb_ff;
         s3_t0sq_ff <= tm0 * tm0;
         s3_t1sq_ff <= tm1 * tm1;
      end
   end

   // ---------------- Stage 4: radicands t^2 - 24 s, clamped ----------------
   logic [RADA_W-1:0] k0, k1, rad0_in, rad1_in;
   logic [DIF_W-1:0]  dif_in;

   always_comb begin
      k0 = ({{(RADA_W-MAG_W){1'b0}}, s3_sa_ff} * RADA_W'(24)) << IFB;
      k1 = ({{(RADA_W-MAG_W){1'b0}}, s3_sb_ff} * RADA_W'(24)) << IFB;
      rad0_in = (s3_t0sq_ff >= k0) ? s3_t0sq_ff - k0 : '0;
      rad1_in = (s3_t1sq_ff >= k1) ? s3_t1sq_ff - k1 : '0;
      dif_in  = {1'b0, s3_sa_ff} - {1'b0, s3_sb_ff};
   end

   // ---------------- Root A: one root bit per stage ----------------
   logic                      ra_vld_ff  [0:STG_A];
   logic [2:0]                ra_face_ff [0:STG_A];
   s2cfm_pkg::sgn_type        ra_sga_ff  [0:STG_A];
   s2cfm_pkg::sgn_type        ra_sgb_ff  [0:STG_A];
   logic signed [DIF_W-1:0]   ra_dif_ff  [0:STG_A];
   logic [RADA_W-1:0]         ra_n0_ff   [0:STG_A];
   logic [RADA_W-1:0]         ra_r0_ff   [0:STG_A];
   logic [RADA_W-1:0]         ra_n1_ff   [0:STG_A];
   logic [RADA_W-1:0]         ra_r1_ff   [0:STG_A];

   always_ff @(posedge clock) begin
      if (reset) begin
         ra_vld_ff[0] <= 1'b0;
      end else if (adv) begin
         ra_vld_ff[0] <= s3_vld_ff;
      end
      if (adv) begin
         ra_face_ff[0] <= s3_face_ff;
         ra_sga_ff[0]  <= s3_sga_ff;
         ra_sgb_ff[0]  <= s3_sgb_ff;
         ra_dif_ff[0]  <= dif_in;
         ra_n0_ff[0]   <= rad0_in;
         ra_r0_ff[0]   <= '0;
         ra_n1_ff[0]   <= rad1_in;
         ra_r1_ff[0]   <= '0;
      end
   end

   for (genvar j = 0; j < STG_A; j++) begin : g_root_a
      localparam logic [RADA_W-1:0] BitA = RADA_W'(1) << (2 * (STG_A - 1 - j));
      logic [RADA_W-1:0] trial0, trial1;

      assign trial0 = ra_r0_ff[j] + BitA;
      assign trial1 = ra_r1_ff[j] + BitA;

      // Subtract the trial and set this root bit where it fits
      always_ff @(posedge clock) begin
         if (reset) begin
            ra_vld_ff[j+1] <= 1'b0;
         end else if (adv) begin
            ra_vld_ff[j+1] <= ra_vld_ff[j];
         end
         if (adv) begin
            ra_face_ff[j+1] <= ra_face_ff[j];
            ra_sga_ff[j+1]  <= ra_sga_ff[j];
            ra_sgb_ff[j+1]  <= ra_sgb_ff[j];
            ra_dif_ff[j+1]  <= ra_dif_ff[j];
            if (ra_n0_ff[j] >= trial0) begin
               ra_n0_ff[j+1] <= ra_n0_ff[j] - trial0;
               ra_r0_ff[j+1] <= (ra_r0_ff[j] >> 1) + BitA;
            end else begin
               ra_n0_ff[j+1] <= ra_n0_ff[j];
               ra_r0_ff[j+1] <= ra_r0_ff[j] >> 1;
            end
            if (ra_n1_ff[j] >= trial1) begin
               ra_n1_ff[j+1] <= ra_n1_ff[j] - trial1;
               ra_r1_ff[j+1] <= (ra_r1_ff[j] >> 1) + BitA;
            end else begin
               ra_n1_ff[j+1] <= ra_n1_ff[j];
               ra_r1_ff[j+1] <= ra_r1_ff[j] >> 1;
            end
         end
      end
   end

   // ---------------- Second radicands: (3 - u - v) / 2 ----------------
   // v1 = -2 dif feeds face_u, v0 = 2 dif feeds face_v
   logic signed [NUM_W-1:0] u0_s, u1_s, dif2, num0, num1;
   logic        [RADB_W-1:0] radb0_in, radb1_in;

   always_comb begin
      u0_s = NUM_W'(ra_r0_ff[STG_A][RTA_W-1:0]);
      u1_s = NUM_W'(ra_r1_ff[STG_A][RTA_W-1:0]);
      dif2 = NUM_W'(ra_dif_ff[STG_A]) <<< 1;
      num0 = (NUM_W'(3) <<< IFB) - u0_s - dif2;
      num1 = (NUM_W'(3) <<< IFB) - u1_s + dif2;
      radb0_in = (num0 > 0) ? RADB_W'(num0) << (IFB - 1) : '0;
      radb1_in = (num1 > 0) ? RADB_W'(num1) << (IFB - 1) : '0;
   end

   // ---------------- Root B: one root bit per stage ----------------
   logic               rb_vld_ff  [0:STG_B];
   logic [2:0]         rb_face_ff [0:STG_B];
   s2cfm_pkg::sgn_type rb_sga_ff  [0:STG_B];
   s2cfm_pkg::sgn_type rb_sgb_ff  [0:STG_B];
   logic [RADB_W-1:0]  rb_nu_ff   [0:STG_B];
   logic [RADB_W-1:0]  rb_ru_ff   [0:STG_B];
   logic [RADB_W-1:0]  rb_nv_ff   [0:STG_B];
   logic [RADB_W-1:0]  rb_rv_ff   [0:STG_B];

   always_ff @(posedge clock) begin
      if (reset) begin
         rb_vld_ff[0] <= 1'b0;
      end else if (adv) begin
         rb_vld_ff[0] <= ra_vld_ff[STG_A];
      end
      if (adv) begin
         rb_face_ff[0] <= ra_face_ff[STG_A];
         rb_sga_ff[0]  <= ra_sga_ff[STG_A];
         rb_sgb_ff[0]  <= ra_sgb_ff[STG_A];
         rb_nu_ff[0]   <= radb1_in;
         rb_ru_ff[0]   <= '0;
         rb_nv_ff[0]   <= radb0_in;
         rb_rv_ff[0]   <= '0;
      end
   end

   for (genvar j = 0; j < STG_B; j++) begin : g_root_b
      localparam logic [RADB_W-1:0] BitB = RADB_W'(1) << (2 * (STG_B - 1 - j));
      logic [RADB_W-1:0] trialu, trialv;

      assign trialu = rb_ru_ff[j] + BitB;
      assign trialv = rb_rv_ff[j] + BitB;

      // Subtract the trial and set this root bit where it fits
      always_ff @(posedge clock) begin
         if (reset) begin
            rb_vld_ff[j+1] <= 1'b0;
         end else if (adv) begin
            rb_vld_ff[j+1] <= rb_vld_ff[j];
         end
         if (adv) begin
            rb_face_ff[j+1] <= rb_face_ff[j];
            rb_sga_ff[j+1]  <= rb_sga_ff[j];
            rb_sgb_ff[j+1]  <= rb_sgb_ff[j];
            if (rb_nu_ff[j] >= trialu) begin
               rb_nu_ff[j+1] <= rb_nu_ff[j] - trialu;
               rb_ru_ff[j+1] <= (rb_ru_ff[j] >> 1) + BitB;
            end else begin
               rb_nu_ff[j+1] <= rb_nu_ff[j];
               rb_ru_ff[j+1] <= rb_ru_ff[j] >> 1;
            end
            if (rb_nv_ff[j] >= trialv) begin
               rb_nv_ff[j+1] <= rb_nv_ff[j] - trialv;
               rb_rv_ff[j+1] <= (rb_rv_ff[j] >> 1) + BitB;
            end else begin
               rb_nv_ff[j+1] <= rb_nv_ff[j];
               rb_rv_ff[j+1] <= rb_rv_ff[j] >> 1;
            end
         end
      end
   end

   // ---------------- Output: round, saturate, apply sign ----------------
   logic [31:0]        wu, wv, su, sv;
   logic signed [31:0] fu, fv;
   logic               rsp_valid_ff;
   logic [2:0]         rsp_face_ff;
   logic [17:0]        rsp_u_ff, rsp_v_ff;

   always_comb begin
      wu = ((32'(rb_ru_ff[STG_B][RTB_W-1:0]) + RndHalf) >> ShO) << ShOL;
      wv = ((32'(rb_rv_ff[STG_B][RTB_W-1:0]) + RndHalf) >> ShO) << ShOL;
      su = (wu > Lim) ? Lim : wu;
      sv = (wv > Lim) ? Lim : wv;
      if (rb_sga_ff[STG_B].zero) begin
         fu = '0;
      end else if (rb_sga_ff[STG_B].neg) begin
         fu = -$signed(su);
      end else begin
         fu = $signed(su);
      end
      if (rb_sgb_ff[STG_B].zero) begin
         fv = '0;
      end else if (rb_sgb_ff[STG_B].neg) begin
         fv = -$signed(sv);
      end else begin
         fv = $signed(sv);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= rb_vld_ff[STG_B];
      end
      if (adv) begin
         rsp_face_ff <= rb_face_ff[STG_B];
         rsp_u_ff    <= fu[17:0];
         rsp_v_ff    <= fv[17:0];
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_face   = rsp_face_ff;
   assign rsp_face_u = $signed(rsp_u_ff);
   assign rsp_face_v = $signed(rsp_v_ff);

endmodule

`default_nettype wire

### tb/testbench.sv
// Testbench for the sphere to cube face map: directed and random vectors.
// Predicts face and (u, v) per beat and checks every result in order.
// Depends on s2cfm_pkg and sphere_to_cube_face_map_top.
`timescale 1ns / 1ps

module testbench;

   localparam int FB = s2cfm_pkg::DEF_FRAC_BITS;
   localparam int IFB = s2cfm_pkg::IFB;
   localparam longint ONE_I = 64'sd1 << IFB;
   localparam int LIMIT = 400000;

   typedef struct {
      logic [2:0]         face;
      logic signed [17:0] u;
      logic signed [17:0] v;
   } face_coord_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic signed [17:0] req_vec_x = 0, req_vec_y = 0, req_vec_z = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [2:0] rsp_face;
   logic signed [17:0] rsp_face_u, rsp_face_v;

   face_coord_type expected_q[$];
   int errors = 0;
   int cycles = 0;
   int stall_mode = 0;

   sphere_to_cube_face_map_top u_top (.*);

   always #5 clock = ~clock;

   // Integer square root, floor
   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic longint mag_q28(longint c);
      longint m;
      m = (c < 0 ? -c : c) << (IFB - FB);
      return (m > ONE_I) ? ONE_I : m;
   endfunction

   function automatic longint radical_root(longint s, longint so);
      longint t, rad;
      t = 2 * so - 2 * s - 3 * ONE_I;
      rad = t * t - ((24 * s) << IFB);
      if (rad < 0) rad = 0;
      return longint'(int_sqrt(rad));
   endfunction

   function automatic logic signed [17:0] coord_out(longint uv, longint c);
      longint num;
      longint unsigned w;
      num = 3 * ONE_I - uv;
      w = 0;
      if (num > 0) w = int_sqrt(unsigned'(num) << (IFB - 1));
      w = (w + (64'd1 << (IFB - FB - 1))) >> (IFB - FB);
      if (w > (64'd1 << FB)) w = 64'd1 << FB;
      if (c == 0) return 18'sd0;
      return (c < 0) ? 18'(-longint'(w)) : 18'(longint'(w));
   endfunction

   function automatic face_coord_type map_vector(longint x, longint y, longint z);
      face_coord_type r;
      longint ax, ay, az, a, b, ma, mb, sa, sb;
      ax = x < 0 ? -x : x;
      ay = y < 0 ? -y : y;
      az = z < 0 ? -z : z;
      if (ax > ay && ax > az) begin
         if (x > 0) begin r.face = s2cfm_pkg::FACE_PX; a = y; end
         else begin r.face = s2cfm_pkg::FACE_NX; a = -y; end
         b = z;
      end else if (ay > ax && ay > az) begin
         if (y > 0) begin r.face = s2cfm_pkg::FACE_PY; a = z; end
         else begin r.face = s2cfm_pkg::FACE_NY; a = -z; end
         b = x;
      end else begin
         if (z > 0) begin r.face = s2cfm_pkg::FACE_PZ; a = x; end
         else begin r.face = s2cfm_pkg::FACE_NZ; a = -x; end
         b = y;
      end
      ma = mag_q28(a);
      mb = mag_q28(b);
      sa = (ma * ma + (64'sd1 << (IFB - 1))) >>> IFB;
      sb = (mb * mb + (64'sd1 << (IFB - 1))) >>> IFB;
      r.u = coord_out(radical_root(sb, sa) + 2 * sb - 2 * sa, a);
      r.v = coord_out(radical_root(sa, sb) + 2 * sa - 2 * sb, b);
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d want %0d", what, got, want);
      errors++;
   endtask

   // Send one beat; hold it until accepted
   task automatic send_vector(logic signed [17:0] x, y, z);
      req_vec_x <= x;
      req_vec_y <= y;
      req_vec_z <= z;
      req_valid <= 1;
      expected_q.insert(expected_q.size(), map_vector(x, y, z));
      do @(posedge clock); while (req_stall);
   endtask

   task automatic idle_gap();
      req_valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clock);
   endtask

   function automatic logic signed [17:0] rand_comp();
      case ($urandom_range(0, 9))
         0: return 18'sd65536;
         1: return -18'sd65536;
         2: return 18'sd0;
         3: return 18'($urandom);              // any 18-bit pattern, out of range too
         4: return $signed(18'($urandom_range(0, 255))) - 18'sd128;
         default: return $signed(18'($urandom_range(0, 131072))) - 18'sd65536;
      endcase
   endfunction

   // Corners, axes, ties and out-of-range magnitudes
   task automatic test_directed();
      send_vector(18'sd65536, 0, 0);
      send_vector(-18'sd65536, 0, 0);
      send_vector(0, 18'sd65536, 0);
      send_vector(0, -18'sd65536, 0);
      send_vector(0, 0, 18'sd65536);
      send_vector(0, 0, -18'sd65536);
      send_vector(0, 0, 0);
      send_vector(18'sd37837, 18'sd37837, 18'sd37837);
      send_vector(-18'sd37837, 18'sd37837, -18'sd37837);
      send_vector(18'sd46341, 18'sd46341, 0);
      send_vector(18'sd46341, -18'sd46341, 18'sd100);
      send_vector(18'sd100, 18'sd46341, 18'sd46341);
      send_vector(18'sd40000, -18'sd30000, 18'sd20000);
      send_vector(-18'sd10, 18'sd60000, -18'sd25000);
      send_vector(18'sd3000, -18'sd5000, -18'sd65000);
      send_vector(18'sh1ffff, 18'sh1ffff, 18'sh1ffff);
      send_vector(18'sh20000, 18'sh20000, 18'sh20000);
      send_vector(18'sh20000, 18'sh1ffff, 18'sd1);
      send_vector(18'sd1, -18'sd1, 18'sd0);
      send_vector(18'sh1ffff, -18'sd70000, 18'sd90000);
      idle_gap();
   endtask

   // Random beats in bursts with gaps
   task automatic test_random(int count);
      int left, burst;
      left = count;
      while (left > 0) begin
         burst = $urandom_range(1, 20);
         if (burst > left) burst = left;
         repeat (burst) send_vector(rand_comp(), rand_comp(), rand_comp());
         left -= burst;
         if ($urandom_range(0, 3) != 0) idle_gap();
      end
      req_valid <= 0;
   endtask

   // Receiver stall pattern: changes mode now and then
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_stall <= 0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= cycles[2];
         default: rsp_stall <= ($urandom_range(0, 1) == 0);
      endcase
   end

   // Check each result beat against the oldest expectation
   always @(posedge clock) begin
      face_coord_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            report_mismatch("unexpected beat", rsp_face, -1);
         end else begin
            e = expected_q.pop_front();
            if (rsp_face !== e.face) report_mismatch("face", rsp_face, e.face);
            if (rsp_face_u !== e.u) report_mismatch("face_u", rsp_face_u, e.u);
            if (rsp_face_v !== e.v) report_mismatch("face_v", rsp_face_v, e.v);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      if (cycles > LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      test_random(450);
      wait (expected_q.size() == 0);
      repeat (100) @(posedge clock);
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
